// File: sv/aabb_broadphase_table_assert.svh
// Assertion macros for the broadphase table.
`ifndef AABB_BROADPHASE_TABLE_ASSERT_SVH
`define AABB_BROADPHASE_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABP_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/abp_pkg.sv
package abp_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int BND_W    = 32;
  localparam int AXES     = 3;
  localparam int AXIS_W   = $clog2(AXES);

  // Action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } act_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Box bounds per axis, index 0 = x, 1 = y, 2 = z
  typedef struct packed {
    logic [AXES-1:0][BND_W-1:0] lo;
    logic [AXES-1:0][BND_W-1:0] hi;
  } box_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0] id;
    box_t            box;
  } entry_t;

endpackage

// File: sv/abp_ram.sv
module abp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/abp_axis_cmp.sv
module abp_axis_cmp (
  input  abp_pkg::box_t              box_a,
  input  abp_pkg::box_t              box_b,
  input  logic [abp_pkg::AXIS_W-1:0] axis,
  output logic                       apart
);

  logic signed [abp_pkg::BND_W-1:0] lo_a;
  logic signed [abp_pkg::BND_W-1:0] hi_a;
  logic signed [abp_pkg::BND_W-1:0] lo_b;
  logic signed [abp_pkg::BND_W-1:0] hi_b;

  // Pick one axis; touching faces are not apart
  always_comb begin
    lo_a  = $signed(box_a.lo[axis]);
    hi_a  = $signed(box_a.hi[axis]);
    lo_b  = $signed(box_b.lo[axis]);
    hi_b  = $signed(box_b.hi[axis]);
    apart = (hi_a < lo_b) || (lo_a > hi_b);
  end

endmodule

// File: sv/aabb_broadphase_table.sv
// Broadphase table of body ids with 3D boxes in signed Q16.16.
// Command channel: an item transfers at a rising edge with start high and
// busy low. action selects insert (body_id and the six bounds), remove
// (body_id) or overlap query (body_id and other_id).
// Result channel: done is high for exactly one cycle with overlap, status
// and entry_count valid; the result transfers at the edge ending that cycle.
// The receiver cannot stall, so a result is never held.
// Steps from the transfer edge to done, with n entries stored:
//   insert or unused action: done follows the transfer with no further steps
//   remove: scan up to n entries, read last entry, write into the slot
//   query: scan up to n entries, read both boxes, test x, y, z
// The scan reads one entry per cycle through the single read port of the
// entry memory, which bounds throughput at about one entry per cycle. busy
// is high from the transfer until done; the next command may transfer in
// the done cycle. Reset empties the table (entry_count 0) and needs no
// clearing pass: entries at or above the count are never read.
`include "aabb_broadphase_table_assert.svh"

module aabb_broadphase_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [abp_pkg::ID_W-1:0]          body_id,
  input  logic [abp_pkg::ID_W-1:0]          other_id,
  input  logic signed [abp_pkg::BND_W-1:0]  min_x,
  input  logic signed [abp_pkg::BND_W-1:0]  min_y,
  input  logic signed [abp_pkg::BND_W-1:0]  min_z,
  input  logic signed [abp_pkg::BND_W-1:0]  max_x,
  input  logic signed [abp_pkg::BND_W-1:0]  max_y,
  input  logic signed [abp_pkg::BND_W-1:0]  max_z,
  output logic                              done,
  output logic                              overlap,
  output logic [1:0]                        status,
  output logic [abp_pkg::CNT_W-1:0]         entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_A,
    S_RD_B,
    S_CMP,
    S_COPY,
    S_WRITE
  } state_t;

  localparam logic [abp_pkg::CNT_W-1:0] CAP_CNT = abp_pkg::CNT_W'(abp_pkg::CAPACITY);
  localparam logic [abp_pkg::AXIS_W-1:0] LAST_AXIS = abp_pkg::AXIS_W'(abp_pkg::AXES - 1);

  state_t                      state;
  abp_pkg::act_t               op;
  logic [abp_pkg::ID_W-1:0]    id_a;
  logic [abp_pkg::ID_W-1:0]    id_b;
  logic [abp_pkg::CNT_W-1:0]   count;
  logic [abp_pkg::CNT_W-1:0]   rd_idx;
  logic                        chk_vld;
  logic [abp_pkg::ADDR_W-1:0]  chk_idx;
  logic                        got_a;
  logic                        got_b;
  logic [abp_pkg::ADDR_W-1:0]  pick_a;
  logic [abp_pkg::ADDR_W-1:0]  pick_b;
  abp_pkg::box_t               box_a;
  logic [abp_pkg::AXIS_W-1:0]  axis;

  logic                        accept;
  logic                        hit_a;
  logic                        hit_b;
  logic                        got_a_next;
  logic                        got_b_next;
  logic                        found;
  logic                        apart;
  logic [abp_pkg::CNT_W-1:0]   count_dec;
  logic                        ram_we;
  logic [abp_pkg::ADDR_W-1:0]  ram_waddr;
  abp_pkg::entry_t             ram_wdata;
  abp_pkg::entry_t             new_entry;
  logic [abp_pkg::ADDR_W-1:0]  ram_raddr;
  abp_pkg::entry_t             rd_entry;

  assign accept      = start && !busy;
  assign busy        = (state != S_IDLE);
  assign entry_count = count;
  assign count_dec   = count - abp_pkg::CNT_W'(1);

  // Scan compare on the entry returned this cycle
  assign hit_a      = chk_vld && (rd_entry.id == id_a);
  assign hit_b      = chk_vld && (rd_entry.id == id_b);
  assign got_a_next = got_a || hit_a;
  assign got_b_next = got_b || hit_b;
  assign found      = (op == abp_pkg::ACT_REMOVE) ? hit_a : (got_a_next && got_b_next);

  // Entry built from the command fields for an insert
  always_comb begin
    new_entry.id        = body_id;
    new_entry.box.lo[0] = min_x;
    new_entry.box.lo[1] = min_y;
    new_entry.box.lo[2] = min_z;
    new_entry.box.hi[0] = max_x;
    new_entry.box.hi[1] = max_y;
    new_entry.box.hi[2] = max_z;
  end

  // Memory write: insert at the tail, or move the last entry into a removed slot
  always_comb begin
    if (state == S_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = pick_a;
      ram_wdata = rd_entry;
    end else begin
      ram_we    = accept && (action == abp_pkg::ACT_INSERT) && (count < CAP_CNT);
      ram_waddr = count[abp_pkg::ADDR_W-1:0];
      ram_wdata = new_entry;
    end
  end

  // Memory read address per step
  always_comb begin
    case (state)
      S_SCAN:         ram_raddr = rd_idx[abp_pkg::ADDR_W-1:0];
      S_RD_A:         ram_raddr = pick_a;
      S_RD_B, S_CMP:  ram_raddr = pick_b;
      S_COPY:         ram_raddr = count_dec[abp_pkg::ADDR_W-1:0];
      default:        ram_raddr = rd_idx[abp_pkg::ADDR_W-1:0];
    endcase
  end

  abp_ram #(
    .WIDTH ($bits(abp_pkg::entry_t)),
    .DEPTH (abp_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // Shared axis test: box a held in a register, box b on the read port
  abp_axis_cmp u_cmp (
    .box_a (box_a),
    .box_b (rd_entry.box),
    .axis  (axis),
    .apart (apart)
  );

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
      overlap <= 1'b0;
      status  <= abp_pkg::ST_DONE;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            id_a    <= body_id;
            id_b    <= other_id;
            op      <= abp_pkg::act_t'(action);
            got_a   <= 1'b0;
            got_b   <= 1'b0;
            rd_idx  <= '0;
            chk_vld <= 1'b0;
            axis    <= '0;
            overlap <= 1'b0;
            case (action)
              abp_pkg::ACT_INSERT: begin
                done <= 1'b1;
                if (count < CAP_CNT) begin
                  count  <= count + abp_pkg::CNT_W'(1);
                  status <= abp_pkg::ST_DONE;
                end else begin
                  status <= abp_pkg::ST_FULL;
                end
              end
              abp_pkg::ACT_REMOVE, abp_pkg::ACT_QUERY: begin
                state <= S_SCAN;
              end
              default: begin
                done   <= 1'b1;
                status <= abp_pkg::ST_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue the next read while checking the previous one
          if (rd_idx < count) begin
            rd_idx  <= rd_idx + abp_pkg::CNT_W'(1);
            chk_vld <= 1'b1;
            chk_idx <= rd_idx[abp_pkg::ADDR_W-1:0];
          end else begin
            chk_vld <= 1'b0;
          end
          if (hit_a) begin
            got_a  <= 1'b1;
            pick_a <= chk_idx;
          end
          if (hit_b) begin
            got_b  <= 1'b1;
            pick_b <= chk_idx;
          end
          if (found) begin
            chk_vld <= 1'b0;
            state   <= (op == abp_pkg::ACT_REMOVE) ? S_COPY : S_RD_A;
          end else if (rd_idx >= count) begin
            done    <= 1'b1;
            overlap <= 1'b0;
            status  <= abp_pkg::ST_MISS;
            state   <= S_IDLE;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          box_a <= rd_entry.box;
          axis  <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          // one axis per cycle, stop at the first separating axis
          if (apart) begin
            done    <= 1'b1;
            overlap <= 1'b0;
            status  <= abp_pkg::ST_DONE;
            state   <= S_IDLE;
          end else if (axis == LAST_AXIS) begin
            done    <= 1'b1;
            overlap <= 1'b1;
            status  <= abp_pkg::ST_DONE;
            state   <= S_IDLE;
          end else begin
            axis <= axis + abp_pkg::AXIS_W'(1);
          end
        end
        S_COPY: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          count   <= count_dec;
          done    <= 1'b1;
          overlap <= 1'b0;
          status  <= abp_pkg::ST_DONE;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ABP_CHECK_NEXT(a_accept_progress, accept, busy || done, "accepted command made no progress")
  `ABP_CHECK_NOW(a_full_only_at_cap, done && (status == abp_pkg::ST_FULL), count == CAP_CNT, "full status below capacity")
  `ABP_CHECK_NOW(a_overlap_done_only, done && overlap, status == abp_pkg::ST_DONE, "overlap reported with error status")
  `ABP_CHECK_NOW(a_count_in_range, ram_we, (state == S_WRITE) || (count < CAP_CNT), "write beyond table")

endmodule
